// File: sv/cifp_pkg.sv
// constants and helpers for the compressed integer field parser
package cifp_pkg;

	// flag thresholds that select the compressed word length
	localparam logic [7:0] FlagTwo   = 8'h80;
	localparam logic [7:0] FlagThree = 8'hC0;
	localparam logic [7:0] FlagFour  = 8'hE0;
	localparam logic [7:0] FlagFive  = 8'hF0;

	// value masks per compressed length
	localparam logic [63:0] MaskOne   = 64'h0000_0000_0000_00FF;
	localparam logic [63:0] MaskTwo   = 64'h0000_0000_0000_7FFF;
	localparam logic [63:0] MaskThree = 64'h0000_0000_003F_FFFF;
	localparam logic [63:0] MaskFour  = 64'h0000_0000_1FFF_FFFF;
	localparam logic [63:0] MaskFive  = 64'h0000_0000_FFFF_FFFF;

	// bytes of the plain low word in pair mode
	localparam logic [3:0] LowWordBytes = 4'd4;

	// output tuser codes
	localparam logic STATUS_DONE       = 1'b0;
	localparam logic STATUS_INCOMPLETE = 1'b1;

	// compressed word length, 1 to 5, from the leading ones of the flag
	function automatic logic [2:0] length_of_flag(input logic [7:0] flag);
		logic [2:0] len;
		if (flag < FlagTwo)
			len = 3'd1;
		else if (flag < FlagThree)
			len = 3'd2;
		else if (flag < FlagFour)
			len = 3'd3;
		else if (flag < FlagFive)
			len = 3'd4;
		else
			len = 3'd5;
		return len;
	endfunction

	// mask applied once the compressed word is complete
	function automatic logic [63:0] mask_of_length(input logic [2:0] len);
		logic [63:0] m;
		case (len)
			3'd1:    m = MaskOne;
			3'd2:    m = MaskTwo;
			3'd3:    m = MaskThree;
			3'd4:    m = MaskFour;
			default: m = MaskFive;
		endcase
		return m;
	endfunction

endpackage

// File: sv/compressed_integer_field_parser.sv
// prefix-length integer field parser, byte stream in, decoded fields out
// output: a field's result appears in the cycle after its last byte transfer
// throughput: one byte per cycle; field state and the output register update together
// input stalls only while the output register holds a result that is not taken
// reset: asynchronous, clears field state except the accumulator, and the output valid
// no clearing pass; ready for bytes as soon as reset is released
module compressed_integer_field_parser
	import cifp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic [0:0]  s_axis_tuser,  // [0] func
	input  logic        s_axis_tlast,  // buffer_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // [63:0] decoded_value, [67:64] field_length, rest zero
	output logic [0:0]  m_axis_tuser   // [0] status
);

	// field state
	logic [3:0]  seen_q;
	logic [2:0]  exp_len_q;
	logic [63:0] acc_q;
	logic        pair_q;

	// output register
	logic        out_valid_q;
	logic        out_status_q;
	logic [63:0] out_value_q;
	logic [3:0]  out_len_q;

	logic        in_xfer;
	logic        first;
	logic [2:0]  exp_len;
	logic        pair;
	logic [63:0] acc_shift;
	logic [63:0] acc_next;
	logic [3:0]  seen_next;
	logic [3:0]  total;
	logic        done;
	logic        emit;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// next field state from the current byte
	always_comb begin
		first     = (seen_q == 4'd0);
		exp_len   = first ? length_of_flag(s_axis_tdata) : exp_len_q;
		pair      = first ? s_axis_tuser[0] : pair_q;
		acc_shift = {(first ? 56'd0 : acc_q[55:0]), s_axis_tdata};
		seen_next = seen_q + 4'd1;
		acc_next  = (seen_next == {1'b0, exp_len}) ?
			(acc_shift & mask_of_length(exp_len)) : acc_shift;
		total     = {1'b0, exp_len} + (pair ? LowWordBytes : 4'd0);
		done      = (seen_next == total);
		emit      = done || s_axis_tlast;
	end

	// field state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= 4'd0;
			exp_len_q <= 3'd0;
			pair_q    <= 1'b0;
		end else if (in_xfer) begin
			if (emit) begin
				seen_q    <= 4'd0;
				exp_len_q <= 3'd0;
				pair_q    <= 1'b0;
			end else begin
				seen_q    <= seen_next;
				exp_len_q <= exp_len;
				pair_q    <= pair;
			end
		end
	end

	// accumulator needs no reset, the first byte of a field reloads it
	always_ff @(posedge clk) begin
		if (in_xfer)
			acc_q <= acc_next;
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (in_xfer && emit)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	// output payload
	always_ff @(posedge clk) begin
		if (in_xfer && emit) begin
			if (done) begin
				out_status_q <= STATUS_DONE;
				out_value_q  <= acc_next;
				out_len_q    <= total;
			end else begin
				out_status_q <= STATUS_INCOMPLETE;
				out_value_q  <= 64'd0;
				out_len_q    <= 4'd0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_len_q, out_value_q};
	assign m_axis_tuser  = out_status_q;

	// input only stalls behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with empty output register");

	// a result always returns the parser to field start
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && emit) |=> (seen_q == 4'd0))
		else $error("parser not at field start after a result");

	// the byte count never passes the longest field
	a_seen_range: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q < 4'd9)
		else $error("byte count out of range");

	// complete results have a length of one to nine bytes
	a_done_len: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0] == STATUS_DONE) |->
		(m_axis_tdata[67:64] != 4'd0 && m_axis_tdata[67:64] < 4'd10))
		else $error("complete field with bad length");

	// incomplete results carry zero value and length
	a_incomplete_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0] == STATUS_INCOMPLETE) |->
		(m_axis_tdata == 72'd0))
		else $error("incomplete field with nonzero payload");

endmodule
